@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the byte stream parser.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/bsp_pkg.sv @@
// ---------------------------------------------------------------------------
// Byte stream parser package
// Types, codes and constants shared by the parser modules.
// ---------------------------------------------------------------------------
`default_nettype none

package bsp_pkg;

   localparam logic [2:0] MODE_HEADER  = 3'd0;
   localparam logic [2:0] MODE_PALETTE = 3'd1;
   localparam logic [2:0] MODE_IMAGE   = 3'd2;
   localparam logic [2:0] MODE_DONE    = 3'd3;
   localparam logic [2:0] MODE_ERROR   = 3'd4;

   localparam logic [1:0] KIND_INFO    = 2'd0;
   localparam logic [1:0] KIND_PALETTE = 2'd1;
   localparam logic [1:0] KIND_IMAGE   = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   localparam logic [1:0] ERR_SIGNATURE   = 2'd0;
   localparam logic [1:0] ERR_HEADER_SIZE = 2'd1;
   localparam logic [1:0] ERR_COMPRESSED  = 2'd2;

   localparam logic [1:0] VAR_WIN    = 2'd0;
   localparam logic [1:0] VAR_OS2_V1 = 2'd1;
   localparam logic [1:0] VAR_OS2_V2 = 2'd2;

   localparam logic [7:0]  SIG_B        = 8'h42;
   localparam logic [7:0]  SIG_M        = 8'h4D;
   localparam logic [31:0] HDR_SIZE_WIN = 32'd40;
   localparam logic [31:0] HDR_SIZE_V1  = 32'd12;
   localparam logic [31:0] HDR_SIZE_V2  = 32'd64;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] number;
      logic [31:0] image_height;
      logic [15:0] bit_depth;
      logic [1:0]  header_variant;
      logic [8:0]  color_count;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  data_byte;
      logic        row_end;
      logic [1:0]  error_code;
   } rsp_word_type;

   typedef struct packed {
      logic        load;
      logic [31:0] width;
      logic [15:0] depth;
   } calc_req_type;

   function automatic logic [8:0] colors_of(input logic [15:0] depth);
      logic [8:0] cc;
      cc = '0;
      if (depth <= 16'd8) begin
         cc = 9'd1 << depth[3:0];
      end
      return cc;
   endfunction

endpackage

`default_nettype wire

@@ src/bsp_stream_if.sv @@
// ---------------------------------------------------------------------------
// Byte stream parser channels
// Valid/ready channels for input bytes and result words.
// ---------------------------------------------------------------------------
`default_nettype none

interface bsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_in;

   modport source (output valid, output data_in, input ready);
   modport sink   (input valid, input data_in, output ready);
endinterface

interface bsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] number;
   logic [31:0] image_height;
   logic [15:0] bit_depth;
   logic [1:0]  header_variant;
   logic [8:0]  color_count;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  data_byte;
   logic        row_end;
   logic [1:0]  error_code;

   modport source (output valid, output kind, output number, output image_height,
                   output bit_depth, output header_variant, output color_count,
                   output red, output green, output blue, output data_byte,
                   output row_end, output error_code, input ready);
   modport sink   (input valid, input kind, input number, input image_height,
                   input bit_depth, input header_variant, input color_count,
                   input red, input green, input blue, input data_byte,
                   input row_end, input error_code, output ready);
endinterface

`default_nettype wire

@@ src/bsp_row_calc.sv @@
// ---------------------------------------------------------------------------
// Row size calculator
// Registered width by depth product and padded row size in bytes.
// ---------------------------------------------------------------------------
`default_nettype none

module bsp_row_calc (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bsp_pkg::calc_req_type calc,
   output logic [31:0]               padded_row_bytes,
   output logic                      busy
);
   import bsp_pkg::*;

   logic [47:0] prod_ff;
   logic [47:0] prod_in;
   logic [31:0] padded_ff;
   logic [31:0] padded_in;
   logic        busy_ff;
   logic [43:0] quads;

   // four bytes per 32 bits, rounded up
   always_comb begin
      prod_in = calc.load ? (48'(calc.width) * 48'(calc.depth)) : prod_ff;
      quads   = {1'b0, prod_ff[47:5]} + 44'(|prod_ff[4:0]);
      if (|quads[43:30]) begin
         padded_in = 32'hFFFF_FFFC;
      end else begin
         padded_in = {quads[29:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff   <= '0;
         padded_ff <= '0;
         busy_ff   <= 1'b0;
      end else begin
         prod_ff   <= prod_in;
         padded_ff <= padded_in;
         busy_ff   <= calc.load;
      end
   end

   assign padded_row_bytes = padded_ff;
   assign busy             = busy_ff;

endmodule

`default_nettype wire

@@ src/bsp_core.sv @@
// ---------------------------------------------------------------------------
// Parser core
// Header field assembly, palette and image row tracking per input word.
// ---------------------------------------------------------------------------
`default_nettype none

module bsp_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            data_in,
   input  wire logic [31:0]           padded_row_bytes,
   output logic                       emit,
   output bsp_pkg::rsp_word_type      word,
   output bsp_pkg::calc_req_type      calc,
   output logic [2:0]                 mode
);
   import bsp_pkg::*;

   localparam logic [6:0] P_SIG0   = 7'd0;
   localparam logic [6:0] P_SIG1   = 7'd1;
   localparam logic [6:0] P_HSIZE  = 7'd17;
   localparam logic [6:0] P_V1_W   = 7'd19;
   localparam logic [6:0] P_V1_H   = 7'd21;
   localparam logic [6:0] P_V1_D   = 7'd25;
   localparam logic [6:0] P_W      = 7'd21;
   localparam logic [6:0] P_H      = 7'd25;
   localparam logic [6:0] P_D      = 7'd29;
   localparam logic [6:0] P_COMP   = 7'd33;
   localparam logic [6:0] P_END_W  = 7'd53;
   localparam logic [6:0] P_END_V2 = 7'd77;
   localparam logic [6:0] P_MAX    = 7'd127;

   logic [2:0]  mode_ff, mode_in;
   logic [6:0]  pos_ff, pos_in;
   logic [31:0] field_ff, field_in;
   logic [1:0]  variant_ff, variant_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic [15:0] depth_ff, depth_in;
   logic [8:0]  pal_idx_ff, pal_idx_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] saved_ff, saved_in;
   logic [31:0] row_bytes_ff, row_bytes_in;
   logic [31:0] row_count_ff, row_count_in;

   logic [31:0] field_next;
   logic        finish;
   logic        err;
   logic [1:0]  err_code;
   logic [8:0]  fin_colors;
   logic [8:0]  idx_inc;
   logic        last;

   always_comb begin
      mode_in      = mode_ff;
      pos_in       = pos_ff;
      field_in     = field_ff;
      variant_in   = variant_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      depth_in     = depth_ff;
      pal_idx_in   = pal_idx_ff;
      phase_in     = phase_ff;
      saved_in     = saved_ff;
      row_bytes_in = row_bytes_ff;
      row_count_in = row_count_ff;
      field_next   = {data_in, field_ff[31:8]};
      finish       = 1'b0;
      err          = 1'b0;
      err_code     = ERR_SIGNATURE;
      emit         = 1'b0;
      word         = '0;
      idx_inc      = pal_idx_ff + 9'd1;
      last         = ({1'b0, row_bytes_ff} + 33'd1) >= {1'b0, padded_row_bytes};

      if (accept) begin
         unique case (mode_ff)
            MODE_HEADER: begin
               field_in = field_next;
               if (pos_ff != P_MAX) begin
                  pos_in = pos_ff + 7'd1;
               end
               if ((pos_ff == P_SIG0 && data_in != SIG_B) ||
                   (pos_ff == P_SIG1 && data_in != SIG_M)) begin
                  err      = 1'b1;
                  err_code = ERR_SIGNATURE;
               end else if (pos_ff == P_HSIZE) begin
                  if (field_next == HDR_SIZE_WIN) begin
                     variant_in = VAR_WIN;
                  end else if (field_next == HDR_SIZE_V1) begin
                     variant_in = VAR_OS2_V1;
                  end else if (field_next == HDR_SIZE_V2) begin
                     variant_in = VAR_OS2_V2;
                  end else begin
                     err      = 1'b1;
                     err_code = ERR_HEADER_SIZE;
                  end
               end else if (pos_ff > P_HSIZE) begin
                  if (variant_ff == VAR_OS2_V1) begin
                     if (pos_ff == P_V1_W) begin
                        width_in = {16'd0, field_next[31:16]};
                     end else if (pos_ff == P_V1_H) begin
                        height_in = {16'd0, field_next[31:16]};
                     end else if (pos_ff == P_V1_D) begin
                        depth_in = field_next[31:16];
                        finish   = 1'b1;
                     end
                  end else begin
                     if (pos_ff == P_W) begin
                        width_in = field_next;
                     end else if (pos_ff == P_H) begin
                        height_in = field_next;
                     end else if (pos_ff == P_D) begin
                        depth_in = field_next[31:16];
                     end else if (pos_ff == P_COMP) begin
                        if (field_next != 32'd0) begin
                           err      = 1'b1;
                           err_code = ERR_COMPRESSED;
                        end
                     end else if (pos_ff == ((variant_ff == VAR_WIN) ? P_END_W : P_END_V2)) begin
                        finish = 1'b1;
                     end
                  end
               end
            end
            MODE_PALETTE: begin
               case (phase_ff)
                  2'd0: begin
                     saved_in = {8'd0, data_in};
                     phase_in = 2'd1;
                  end
                  2'd1: begin
                     saved_in = {data_in, saved_ff[7:0]};
                     phase_in = 2'd2;
                  end
                  2'd2: begin
                     emit        = 1'b1;
                     word.kind   = KIND_PALETTE;
                     word.number = {23'd0, pal_idx_ff};
                     word.red    = data_in;
                     word.green  = saved_ff[15:8];
                     word.blue   = saved_ff[7:0];
                     phase_in    = 2'd3;
                  end
                  default: ;
               endcase
               // advance to the next entry
               if ((phase_ff == 2'd2 && variant_ff == VAR_OS2_V1) || phase_ff == 2'd3) begin
                  phase_in   = 2'd0;
                  pal_idx_in = idx_inc;
                  if (idx_inc >= colors_of(depth_ff)) begin
                     row_bytes_in = '0;
                     row_count_in = '0;
                     mode_in = (height_ff == 32'd0 || padded_row_bytes == 32'd0) ?
                               MODE_DONE : MODE_IMAGE;
                  end
               end
            end
            MODE_IMAGE: begin
               emit           = 1'b1;
               word.kind      = KIND_IMAGE;
               word.number    = row_count_ff;
               word.data_byte = data_in;
               word.row_end   = last;
               if (last) begin
                  row_bytes_in = '0;
                  row_count_in = row_count_ff + 32'd1;
                  if (row_count_in >= height_ff) begin
                     mode_in = MODE_DONE;
                  end
               end else begin
                  row_bytes_in = row_bytes_ff + 32'd1;
               end
            end
            default: ;
         endcase
      end

      fin_colors = colors_of(depth_in);
      if (finish) begin
         emit                = 1'b1;
         word.kind           = KIND_INFO;
         word.number         = width_ff;
         word.image_height   = height_ff;
         word.bit_depth      = depth_in;
         word.header_variant = variant_ff;
         word.color_count    = fin_colors;
         pal_idx_in          = '0;
         phase_in            = 2'd0;
         saved_in            = '0;
         if (fin_colors != 9'd0) begin
            mode_in = MODE_PALETTE;
         end else begin
            row_bytes_in = '0;
            row_count_in = '0;
            mode_in = (height_ff == 32'd0 || width_ff == 32'd0 || depth_in == 16'd0) ?
                      MODE_DONE : MODE_IMAGE;
         end
      end

      if (err) begin
         emit            = 1'b1;
         word            = '0;
         word.kind       = KIND_ERROR;
         word.error_code = err_code;
         mode_in         = MODE_ERROR;
      end

      calc.load  = finish;
      calc.width = width_ff;
      calc.depth = depth_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_HEADER;
         pos_ff       <= '0;
         field_ff     <= '0;
         variant_ff   <= VAR_WIN;
         width_ff     <= '0;
         height_ff    <= '0;
         depth_ff     <= '0;
         pal_idx_ff   <= '0;
         phase_ff     <= '0;
         saved_ff     <= '0;
         row_bytes_ff <= '0;
         row_count_ff <= '0;
      end else begin
         mode_ff      <= mode_in;
         pos_ff       <= pos_in;
         field_ff     <= field_in;
         variant_ff   <= variant_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         depth_ff     <= depth_in;
         pal_idx_ff   <= pal_idx_in;
         phase_ff     <= phase_in;
         saved_ff     <= saved_in;
         row_bytes_ff <= row_bytes_in;
         row_count_ff <= row_count_in;
      end
   end

   assign mode = mode_ff;

endmodule

`default_nettype wire

@@ src/bmp_stream_parser_top.sv @@
// Latency: a result word appears in the cycle after its input word is accepted.
// Throughput: one input word per cycle unless the output or the row calculator stalls
// it; the output register takes a new word while the previous one drains. After the
// last header word the input pauses while the registered width-by-depth multiplier sets the row size.
// Reset: synchronous, active high; returns to header parsing with all counters clear.
// ---------------------------------------------------------------------------
// BMP byte stream parser
// Header decode, palette entries and padded image rows from a byte stream.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bmp_stream_parser_top (
   input  wire logic  clock,
   input  wire logic  reset,
   bsp_req_if.sink    req_ch,
   bsp_rsp_if.source  rsp_ch
);
   import bsp_pkg::*;

   logic         accept;
   logic         emit;
   rsp_word_type word;
   calc_req_type calc;
   logic [2:0]   mode;
   logic [31:0]  padded_row_bytes;
   logic         busy;

   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff, out_word_in;

   assign req_ch.ready = !busy && (!out_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   bsp_core u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .data_in          (req_ch.data_in),
      .padded_row_bytes (padded_row_bytes),
      .emit             (emit),
      .word             (word),
      .calc             (calc),
      .mode             (mode)
   );

   bsp_row_calc u_row_calc (
      .clock            (clock),
      .reset            (reset),
      .calc             (calc),
      .padded_row_bytes (padded_row_bytes),
      .busy             (busy)
   );

   always_comb begin
      out_word_in  = out_word_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      if (accept && emit) begin
         out_word_in  = word;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_word_ff <= out_word_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.kind           = out_word_ff.kind;
   assign rsp_ch.number         = out_word_ff.number;
   assign rsp_ch.image_height   = out_word_ff.image_height;
   assign rsp_ch.bit_depth      = out_word_ff.bit_depth;
   assign rsp_ch.header_variant = out_word_ff.header_variant;
   assign rsp_ch.color_count    = out_word_ff.color_count;
   assign rsp_ch.red            = out_word_ff.red;
   assign rsp_ch.green          = out_word_ff.green;
   assign rsp_ch.blue           = out_word_ff.blue;
   assign rsp_ch.data_byte      = out_word_ff.data_byte;
   assign rsp_ch.row_end        = out_word_ff.row_end;
   assign rsp_ch.error_code     = out_word_ff.error_code;

   `ASSERT_IMPLIES(a_image_row_size, clock, reset, (mode == MODE_IMAGE && !busy), (padded_row_bytes != 32'd0), "image mode with zero row size")
   `ASSERT_NEXT(a_error_sticks, clock, reset, (accept && emit && word.kind == KIND_ERROR), (mode == MODE_ERROR), "error word without error mode")
   `ASSERT_IMPLIES(a_quiet_when_over, clock, reset, (mode == MODE_DONE || mode == MODE_ERROR), (!emit), "result emitted after end of stream")

endmodule

`default_nettype wire

@@ tb/bmp_parse_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// BMP stream parser checker
// Watches both channels, parses every accepted input byte with its own copy
// of the header, palette and row state, and compares each result word, field
// by field, with the oldest word it expects.
// ---------------------------------------------------------------------------

module bmp_parse_checker (
   input  logic clock,
   input  logic reset,
   bsp_req_if   req,
   bsp_rsp_if   rsp,
   output int   pending,
   output int   fail_count
);
   import bsp_pkg::*;

   rsp_word_type expected_words[$];
   int           errors = 0;

   logic [2:0]  mode;
   logic [6:0]  hdr_pos;
   logic [31:0] shift_reg;
   logic [1:0]  variant;
   logic [31:0] img_width;
   logic [31:0] img_height;
   logic [15:0] img_depth;
   logic [8:0]  pal_index;
   logic [1:0]  pal_phase;
   logic [15:0] pal_bg;
   logic [31:0] row_bytes;
   logic [31:0] row_pos;
   logic [31:0] row_num;

   assign fail_count = errors;

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 100) $display("mismatch: %s", msg);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   function automatic logic [8:0] palette_size(input logic [15:0] d);
      return (d <= 16'd8) ? (9'd1 << d[3:0]) : 9'd0;
   endfunction

   task automatic clear_state();
      mode       = MODE_HEADER;
      hdr_pos    = '0;
      shift_reg  = '0;
      variant    = VAR_WIN;
      img_width  = '0;
      img_height = '0;
      img_depth  = '0;
      pal_index  = '0;
      pal_phase  = '0;
      pal_bg     = '0;
      row_bytes  = '0;
      row_pos    = '0;
      row_num    = '0;
   endtask

   task automatic raise_error(input logic [1:0] code);
      rsp_word_type w;
      w            = '0;
      w.kind       = KIND_ERROR;
      w.error_code = code;
      expected_words.push_back(w);
      mode = MODE_ERROR;
   endtask

   task automatic start_image();
      row_pos = '0;
      row_num = '0;
      mode = (img_height == 0 || row_bytes == 0) ? MODE_DONE : MODE_IMAGE;
   endtask

   task automatic finish_header();
      rsp_word_type w;
      logic [63:0]  rb;
      rb = (64'(img_width) * 64'(img_depth) + 64'd7) >> 3;
      if (rb[1:0] != 2'd0) rb = rb + 64'd4 - 64'(rb[1:0]);
      row_bytes = (rb > 64'hFFFF_FFFC) ? 32'hFFFF_FFFC : rb[31:0];
      w                = '0;
      w.kind           = KIND_INFO;
      w.number         = img_width;
      w.image_height   = img_height;
      w.bit_depth      = img_depth;
      w.header_variant = variant;
      w.color_count    = palette_size(img_depth);
      expected_words.push_back(w);
      pal_index = '0;
      pal_phase = '0;
      pal_bg    = '0;
      if (w.color_count != 0) mode = MODE_PALETTE;
      else start_image();
   endtask

   task automatic header_byte(input logic [7:0] b);
      logic [6:0] pos;
      pos = hdr_pos;
      shift_reg = {b, shift_reg[31:8]};
      if (hdr_pos < 7'd127) hdr_pos++;
      if ((pos == 0 && b != SIG_B) || (pos == 1 && b != SIG_M)) begin
         raise_error(ERR_SIGNATURE);
      end else if (pos == 17) begin
         if (shift_reg == HDR_SIZE_WIN) variant = VAR_WIN;
         else if (shift_reg == HDR_SIZE_V1) variant = VAR_OS2_V1;
         else if (shift_reg == HDR_SIZE_V2) variant = VAR_OS2_V2;
         else raise_error(ERR_HEADER_SIZE);
      end else if (pos >= 18 && variant == VAR_OS2_V1) begin
         case (pos)
            19: img_width = {16'd0, shift_reg[31:16]};
            21: img_height = {16'd0, shift_reg[31:16]};
            25: begin
               img_depth = shift_reg[31:16];
               finish_header();
            end
            default: ;
         endcase
      end else if (pos >= 18) begin
         case (pos)
            21: img_width = shift_reg;
            25: img_height = shift_reg;
            29: img_depth = shift_reg[31:16];
            33: if (shift_reg != 0) raise_error(ERR_COMPRESSED);
            default: if (pos == ((variant == VAR_WIN) ? 7'd53 : 7'd77)) finish_header();
         endcase
      end
   endtask

   task automatic next_entry();
      pal_phase = '0;
      pal_index = pal_index + 9'd1;
      if (pal_index >= palette_size(img_depth)) start_image();
   endtask

   task automatic palette_byte(input logic [7:0] b);
      rsp_word_type w;
      case (pal_phase)
         2'd0: begin
            pal_bg    = {8'd0, b};
            pal_phase = 2'd1;
         end
         2'd1: begin
            pal_bg    = {b, pal_bg[7:0]};
            pal_phase = 2'd2;
         end
         2'd2: begin
            w        = '0;
            w.kind   = KIND_PALETTE;
            w.number = {23'd0, pal_index};
            w.red    = b;
            w.green  = pal_bg[15:8];
            w.blue   = pal_bg[7:0];
            expected_words.push_back(w);
            if (variant == VAR_OS2_V1) next_entry();
            else pal_phase = 2'd3;
         end
         default: next_entry();
      endcase
   endtask

   task automatic image_byte(input logic [7:0] b);
      rsp_word_type w;
      logic         last;
      last        = ({1'b0, row_pos} + 33'd1 >= {1'b0, row_bytes});
      w           = '0;
      w.kind      = KIND_IMAGE;
      w.number    = row_num;
      w.data_byte = b;
      w.row_end   = last;
      expected_words.push_back(w);
      if (last) begin
         row_pos = '0;
         row_num = row_num + 32'd1;
         if (row_num >= img_height) mode = MODE_DONE;
      end else begin
         row_pos = row_pos + 32'd1;
      end
   endtask

   task automatic parse_byte(input logic [7:0] b);
      case (mode)
         MODE_HEADER:  header_byte(b);
         MODE_PALETTE: palette_byte(b);
         MODE_IMAGE:   image_byte(b);
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         clear_state();
         expected_words.delete();
         pending <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.kind           = rsp.kind;
            got.number         = rsp.number;
            got.image_height   = rsp.image_height;
            got.bit_depth      = rsp.bit_depth;
            got.header_variant = rsp.header_variant;
            got.color_count    = rsp.color_count;
            got.red            = rsp.red;
            got.green          = rsp.green;
            got.blue           = rsp.blue;
            got.data_byte      = rsp.data_byte;
            got.row_end        = rsp.row_end;
            got.error_code     = rsp.error_code;
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("word of kind %0d with nothing expected", got.kind));
            end else begin
               want = expected_words.pop_front();
               compare_field("kind", got.kind, want.kind);
               compare_field("number", got.number, want.number);
               compare_field("image_height", got.image_height, want.image_height);
               compare_field("bit_depth", got.bit_depth, want.bit_depth);
               compare_field("header_variant", got.header_variant, want.header_variant);
               compare_field("color_count", got.color_count, want.color_count);
               compare_field("red", got.red, want.red);
               compare_field("green", got.green, want.green);
               compare_field("blue", got.blue, want.blue);
               compare_field("data_byte", got.data_byte, want.data_byte);
               compare_field("row_end", got.row_end, want.row_end);
               compare_field("error_code", got.error_code, want.error_code);
            end
         end
         if (req.valid && req.ready) parse_byte(req.data_in);
         pending <= expected_words.size();
      end
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// BMP stream parser testbench
// Builds one BMP file per run, its shape picked at random: a plain image, an
// empty image, an oversized row, or a file broken by a bad mark, an unknown
// header size or compression. Streams it with random gaps and stalls and
// gives the verdict from the checker's count.
// ---------------------------------------------------------------------------

module tb_top;
   import bsp_pkg::*;

   localparam int unsigned FILE_ITEMS  = 1900;
   localparam int unsigned QUIET_LIMIT = 2000;

   typedef enum {
      FILE_PLAIN, FILE_BAD_MARK, FILE_BAD_SIZE, FILE_COMPRESSED, FILE_EMPTY, FILE_WIDE
   } file_kind_type;

   logic        clock;
   logic        reset;
   int          pending_words;
   int          fail_count;
   int unsigned quiet_cycles = 0;
   int unsigned pause_at;
   bit          send_idle = 1'b0;
   bit          drain_idle = 1'b0;
   logic [7:0]  file_bytes[$];

   bsp_req_if req_ch();
   bsp_rsp_if rsp_ch();

   bmp_stream_parser_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   bmp_parse_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .pending    (pending_words),
      .fail_count (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic put_bytes(input logic [31:0] v, input int unsigned count);
      for (int k = 0; k < count; k++) file_bytes.push_back(v[8*k +: 8]);
   endtask

   task automatic put_noise(input int unsigned count);
      repeat (count) file_bytes.push_back(8'($urandom));
   endtask

   task automatic put_header(input logic [31:0] hdr_size, input logic [31:0] width,
                             input logic [31:0] height, input logic [15:0] depth,
                             input logic [31:0] comp);
      put_bytes({SIG_M, SIG_B}, 2);
      put_noise(12);
      put_bytes(hdr_size, 4);
      if (hdr_size == HDR_SIZE_V1) begin
         put_bytes(width, 2);
         put_bytes(height, 2);
         put_bytes($urandom, 2);
         put_bytes(depth, 2);
      end else begin
         put_bytes(width, 4);
         put_bytes(height, 4);
         put_bytes($urandom, 2);
         put_bytes(depth, 2);
         put_bytes(comp, 4);
         put_noise((hdr_size == HDR_SIZE_V2) ? 44 : 20);
      end
   endtask

   task automatic build_file();
      file_kind_type kind;
      logic [31:0]   hdr_size;
      logic [31:0]   width;
      logic [31:0]   height;
      logic [31:0]   comp;
      logic [15:0]   depth;
      logic [7:0]    bad;
      int unsigned   pick, sub, row, fill, hlen, entry_len, pal, img;
      pick = $urandom_range(0, 19);
      kind = (pick == 0) ? FILE_BAD_MARK :
             (pick == 1) ? FILE_BAD_SIZE :
             (pick == 2) ? FILE_COMPRESSED :
             (pick < 5)  ? FILE_EMPTY :
             (pick < 7)  ? FILE_WIDE : FILE_PLAIN;
      case ($urandom_range(0, 2))
         0:       hdr_size = HDR_SIZE_WIN;
         1:       hdr_size = HDR_SIZE_V1;
         default: hdr_size = HDR_SIZE_V2;
      endcase
      width  = $urandom_range(1, 200);
      height = 1;
      depth  = 8;
      comp   = 0;
      img    = 0;
      row    = 0;
      case (kind)
         FILE_PLAIN: begin
            case ($urandom_range(0, 7))
               0:       depth = 1;
               1:       depth = 2;
               2:       depth = 4;
               3:       depth = 8;
               4:       depth = 16;
               5:       depth = 24;
               6:       depth = 32;
               default: depth = $urandom_range(1, 40);
            endcase
            if (depth > 8) width = $urandom_range(1, 48);
            row = ((((width * depth) + 7) >> 3) + 3) & 32'hFFFF_FFFC;
         end
         FILE_EMPTY: begin
            case ($urandom_range(0, 2))
               0: begin
                  height = 0;
                  depth  = $urandom_range(1, 8);
               end
               1:       width = 0;
               default: depth = 0;
            endcase
         end
         FILE_WIDE: begin
            hdr_size = $urandom_range(0, 1) ? HDR_SIZE_WIN : HDR_SIZE_V2;
            width    = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
            depth    = $urandom_range(0, 1) ? 16'hFFFF : 16'd32;
            height   = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(1, 1000);
         end
         FILE_BAD_SIZE: begin
            do hdr_size = $urandom_range(0, 1) ? $urandom_range(0, 80) : $urandom;
            while (hdr_size == HDR_SIZE_WIN || hdr_size == HDR_SIZE_V1 ||
                   hdr_size == HDR_SIZE_V2);
         end
         FILE_COMPRESSED: begin
            hdr_size = $urandom_range(0, 1) ? HDR_SIZE_WIN : HDR_SIZE_V2;
            comp = $urandom_range(0, 1) ? ($urandom | 32'd1) :
                   (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
         end
         default: ;
      endcase
      hlen      = (hdr_size == HDR_SIZE_V1) ? 26 : (hdr_size == HDR_SIZE_V2) ? 78 : 54;
      entry_len = (hdr_size == HDR_SIZE_V1) ? 3 : 4;
      pal = ((kind == FILE_PLAIN || kind == FILE_EMPTY) && depth <= 16'd8) ?
            (1 << depth) * entry_len : 0;
      if (kind == FILE_PLAIN) begin
         fill   = FILE_ITEMS - hlen - pal;
         height = (fill / row > 0) ? fill / row : 1;
         img    = height * row;
      end else if (kind == FILE_WIDE) begin
         img = FILE_ITEMS - hlen;
      end
      put_header(hdr_size, width, height, depth, comp);
      if (kind == FILE_BAD_MARK) begin
         sub = $urandom_range(0, 1);
         do bad = 8'($urandom);
         while (bad == ((sub != 0) ? SIG_M : SIG_B));
         file_bytes[sub] = bad;
      end
      for (int k = 0; k < pal + img; k++) begin
         if (pal != 0 && k < entry_len) file_bytes.push_back(8'h00);
         else if (pal != 0 && k < 2 * entry_len) file_bytes.push_back(8'hFF);
         else file_bytes.push_back(8'($urandom));
      end
      // pad short files with trailing bytes to be dropped
      while (file_bytes.size() < FILE_ITEMS) file_bytes.push_back(8'($urandom));
      put_noise($urandom_range(8, 24));
      pause_at = hlen;
   endtask

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("FAILURE");
      $finish;
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (drain_idle && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      int unsigned n;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.data_in <= '0;
      build_file();
      n = file_bytes.size();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < n; i++) begin
         if ((n - i) <= n / 4) begin
            send_idle  = 1'b0;
            drain_idle = 1'b0;
         end else if (i % 128 == 0) begin
            send_idle  = ($urandom_range(0, 3) != 0);
            drain_idle = ($urandom_range(0, 3) != 0);
         end
         if (i == pause_at) begin
            // hold until the header has drained
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (pending_words != 0) @(posedge clock);
         end else if (send_idle && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         req_ch.valid   <= 1'b1;
         req_ch.data_in <= file_bytes[i];
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+src
src/bsp_pkg.sv
src/bsp_stream_if.sv
src/bsp_row_calc.sv
src/bsp_core.sv
src/bmp_stream_parser_top.sv
tb/bmp_parse_checker.sv
tb/tb_top.sv
